/* rtl/core/assert_macros.svh */
// Assertion macros shared by the field-code filter RTL.
// Each macro places one labeled concurrent assertion clocked on the given clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dfcf_pkg.sv */
// Package for the field-code text filter: control byte codes and shared types.
// No dependencies; used by dfcf_stack, dfcf_map and doc_field_code_text_filter.
`timescale 1ns / 1ps

package dfcf_pkg;

    // Field code markers.
    localparam logic [7:0] CODE_BEGIN = 8'h13;
    localparam logic [7:0] CODE_SEP   = 8'h14;
    localparam logic [7:0] CODE_END   = 8'h15;

    // Text bytes with special handling.
    localparam logic [7:0] CODE_TAB        = 8'h09;
    localparam logic [7:0] CODE_NBHYPHEN   = 8'h1E;
    localparam logic [7:0] CODE_OPTHYPHEN  = 8'h1F;
    localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
    localparam logic [7:0] HYPHEN_CHAR     = 8'h2D;

    // Status handed from the field stack to the byte mapper.
    typedef struct packed {
        logic hidden;    // some open field is still in its instruction part
        logic overflow;  // sticky overflow flag including this item's update
    } dfcf_status_t;

endpackage

/* rtl/core/dfcf_stack.sv */
// Field nesting stack for the field-code text filter: stack bits, level and hidden count.
// Depends on dfcf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfcf_stack #(
    parameter int MAX_NEST = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           in_byte,
    output dfcf_pkg::dfcf_status_t status
);

    localparam int LVL_W = $clog2(MAX_NEST + 1);

    // The stack is a shift line with the innermost open field in bit 0.
    logic [MAX_NEST-1:0] stack_reg, stack_next;
    logic [LVL_W-1:0]    level_reg, level_next;
    logic [LVL_W-1:0]    count_reg, count_next;
    logic                overflow_reg, overflow_next;

    always_comb begin
        stack_next    = stack_reg;
        level_next    = level_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (step) begin
            case (in_byte)
                dfcf_pkg::CODE_BEGIN: begin
                    if (level_reg != LVL_W'(MAX_NEST)) begin
                        stack_next = (stack_reg << 1) | MAX_NEST'(1);
                        level_next = level_reg + LVL_W'(1);
                        count_next = count_reg + LVL_W'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                end
                dfcf_pkg::CODE_SEP: begin
                    if (stack_reg[0]) begin
                        stack_next = stack_reg & ~MAX_NEST'(1);
                        count_next = count_reg - LVL_W'(1);
                    end
                end
                dfcf_pkg::CODE_END: begin
                    if (level_reg != '0) begin
                        if (stack_reg[0]) begin
                            count_next = count_reg - LVL_W'(1);
                        end
                        stack_next = stack_reg >> 1;
                        level_next = level_reg - LVL_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_reg    <= '0;
            level_reg    <= '0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end else begin
            stack_reg    <= stack_next;
            level_reg    <= level_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // Hiding is decided on the state before this item; codes are dropped anyway.
    assign status.hidden   = (count_reg != '0);
    assign status.overflow = overflow_next;

    `ASSERT_ALWAYS(a_count_le_level, aclk, aresetn, count_reg <= level_reg,
        "hidden count exceeds stack level")
    `ASSERT_ALWAYS(a_level_in_range, aclk, aresetn, level_reg <= LVL_W'(MAX_NEST),
        "stack level exceeds maximum nesting")
    `ASSERT_NEXT(a_overflow_sticky, aclk, aresetn, overflow_reg, overflow_reg,
        "overflow flag cleared outside reset")

endmodule

/* rtl/core/dfcf_map.sv */
// Byte classifier and mapper for the field-code text filter.
// Depends on dfcf_pkg.
`timescale 1ns / 1ps

module dfcf_map (
    input  logic                   [7:0] in_byte,
    input  dfcf_pkg::dfcf_status_t       status,
    output logic                         kept,
    output logic                   [7:0] out_byte
);

    logic is_code;

    assign is_code = (in_byte == dfcf_pkg::CODE_BEGIN) ||
                     (in_byte == dfcf_pkg::CODE_SEP)   ||
                     (in_byte == dfcf_pkg::CODE_END);

    always_comb begin
        kept     = 1'b0;
        out_byte = 8'h00;
        if (!is_code && !status.hidden) begin
            if (in_byte == dfcf_pkg::CODE_TAB) begin
                kept     = 1'b1;
                out_byte = in_byte;
            end else if (in_byte == dfcf_pkg::CODE_NBHYPHEN) begin
                kept     = 1'b1;
                out_byte = dfcf_pkg::HYPHEN_CHAR;
            end else if (in_byte >= dfcf_pkg::FIRST_PRINTABLE) begin
                kept     = 1'b1;
                out_byte = in_byte;
            end
        end
    end

endmodule

/* rtl/core/doc_field_code_text_filter.sv */
// Channel  Direction  Ports                                       Item
// s_       in         s_valid s_ready s_in_byte                   one raw text byte
// m_       out        m_valid m_ready m_kept m_out_byte            one filtered byte
//                     m_nest_overflow
//
// Every input item yields exactly one result item, valid the cycle after acceptance.
// Throughput is one item per clock while m_ready is high; one stack step per byte.
// s_ready stays high while the result register is empty or being drained this cycle.
// A stall on m_ready holds the result register and pushes back on s_ready only.
// aresetn is synchronous and active low; it empties the stack and clears overflow.
//
// Top level of the field-code text filter. Depends on dfcf_pkg, dfcf_stack, dfcf_map
// and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module doc_field_code_text_filter #(
    parameter int MAX_NEST = 16
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kept,
    output logic [7:0] m_out_byte,
    output logic       m_nest_overflow
);

    // An item is taken whenever the result register is free or frees up this cycle,
    // so a waiting result never blocks the next byte for more than the stall itself.
    logic accept;
    logic valid_reg, valid_next;
    logic kept_reg;
    logic [7:0] byte_reg;
    logic overflow_reg;

    dfcf_pkg::dfcf_status_t status;
    logic       kept_c;
    logic [7:0] byte_c;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // The stack holds the nesting state; it advances only on an accepted item.
    dfcf_stack #(
        .MAX_NEST (MAX_NEST)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .in_byte (s_in_byte),
        .status  (status)
    );

    // The mapper decides visibility from the pre-update hidden state.
    dfcf_map u_map (
        .in_byte  (s_in_byte),
        .status   (status),
        .kept     (kept_c),
        .out_byte (byte_c)
    );

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Result payload needs no reset; it is only looked at while m_valid is high.
    always_ff @(posedge aclk) begin
        if (accept) begin
            kept_reg     <= kept_c;
            byte_reg     <= byte_c;
            overflow_reg <= status.overflow;
        end
    end

    assign m_valid         = valid_reg;
    assign m_kept          = kept_reg;
    assign m_out_byte      = byte_reg;
    assign m_nest_overflow = overflow_reg;

    `ASSERT_IMPLY(a_dropped_is_zero, aclk, aresetn, valid_reg && !kept_reg,
        byte_reg == 8'h00, "dropped item carries a nonzero byte")
    `ASSERT_NEXT(a_begin_dropped, aclk, aresetn,
        accept && (s_in_byte == dfcf_pkg::CODE_BEGIN), valid_reg && !kept_reg,
        "field begin byte was not dropped")
    `ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !valid_reg, s_ready,
        "input stalled while result register is empty")

endmodule

/* tb/tb_doc_field_code_text_filter.sv */
// Self-checking testbench for the field-code text filter doc_field_code_text_filter.
// Depends on dfcf_pkg for the control byte codes; random field streams and the
// unfixed directed rows are scored against a cycle-free predictor of the field stack.
`timescale 1ns / 1ps

module tb_doc_field_code_text_filter;

    localparam int NEST_DEPTH    = 16;
    localparam int RANDOM_BYTES  = 950;
    localparam int STALL_LIMIT   = 2000;   // cycles with no handshake on either side
    localparam int HOLD_CYCLES   = 250;    // long receiver hold-off, once
    localparam int HOLD_AT       = 300;    // bytes sent before the hold-off starts
    localparam int CALM_FROM     = 600;    // bytes sent when the no-idle stretch starts
    localparam int CALM_TO       = 760;
    localparam int DRAIN_CYCLES  = 10;
    localparam int IDLE_PERCENT  = 31;

    // One filtered item as it leaves the block.
    typedef struct packed {
        logic       kept;
        logic [7:0] out_byte;
        logic       ovf;
    } filt_result_t;

    // One row of the directed table. Rows with fixed set carry a typed-in result;
    // the others are scored against the predictor. reps repeats the row's byte.
    typedef struct packed {
        logic [7:0] in_byte;
        logic [4:0] reps;
        logic       fixed;
        logic       kept;
        logic [7:0] out_byte;
        logic       ovf;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 27;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Plain text straight after reset, including the extremes of the byte range.
        '{8'h41,                5'd1,  1'b1, 1'b1, 8'h41, 1'b0},
        '{8'h00,                5'd1,  1'b1, 1'b0, 8'h00, 1'b0},
        '{8'hFF,                5'd1,  1'b1, 1'b1, 8'hFF, 1'b0},
        '{8'h20,                5'd1,  1'b1, 1'b1, 8'h20, 1'b0},
        '{8'h09,                5'd1,  1'b1, 1'b1, 8'h09, 1'b0},
        '{8'h1E,                5'd1,  1'b1, 1'b1, 8'h2D, 1'b0},
        '{8'h1F,                5'd1,  1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h1D,                5'd1,  1'b1, 1'b0, 8'h00, 1'b0},
        // Separator and end with no open field are dropped and change nothing.
        '{dfcf_pkg::CODE_SEP,   5'd1,  1'b1, 1'b0, 8'h00, 1'b0},
        '{dfcf_pkg::CODE_END,   5'd1,  1'b1, 1'b0, 8'h00, 1'b0},
        // A complete field: hidden instruction, a repeated separator, shown result.
        '{dfcf_pkg::CODE_BEGIN, 5'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h78,                5'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{dfcf_pkg::CODE_SEP,   5'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{dfcf_pkg::CODE_SEP,   5'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h79,                5'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{dfcf_pkg::CODE_END,   5'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        // A field with no separator holding a nested field that has one.
        '{dfcf_pkg::CODE_BEGIN, 5'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h7A,                5'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{dfcf_pkg::CODE_BEGIN, 5'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{dfcf_pkg::CODE_SEP,   5'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h71,                5'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{dfcf_pkg::CODE_END,   5'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{dfcf_pkg::CODE_END,   5'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        // Fill the stack and open one more field to raise the sticky overflow flag.
        '{dfcf_pkg::CODE_BEGIN, 5'd17, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h7F,                5'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{dfcf_pkg::CODE_END,   5'd16, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h42,                5'd1,  1'b0, 1'b0, 8'h00, 1'b0}
    };

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte       = 8'h00;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic       m_kept;
    logic [7:0] m_out_byte;
    logic       m_nest_overflow;

    // Predictor copy of the field stack.
    logic        instr_open [NEST_DEPTH];
    int unsigned open_fields;
    int unsigned hidden_fields;
    logic        overflow_flag;

    filt_result_t filtered_q [$];
    int           mismatches  = 0;
    int           bytes_sent  = 0;
    int           quiet_cycles = 0;

    doc_field_code_text_filter #(
        .MAX_NEST(NEST_DEPTH)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kept         (m_kept),
        .m_out_byte     (m_out_byte),
        .m_nest_overflow(m_nest_overflow)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Advances the predicted field stack by one byte and returns the item the
    // block should produce for it.
    function automatic filt_result_t filter_byte(input logic [7:0] b);
        filt_result_t r;
        r = '0;
        if (b == dfcf_pkg::CODE_BEGIN) begin
            if (open_fields < NEST_DEPTH) begin
                instr_open[open_fields] = 1'b1;
                open_fields++;
                hidden_fields++;
            end else begin
                overflow_flag = 1'b1;
            end
        end else if (b == dfcf_pkg::CODE_SEP) begin
            if (open_fields > 0 && instr_open[open_fields - 1]) begin
                instr_open[open_fields - 1] = 1'b0;
                if (hidden_fields > 0) hidden_fields--;
            end
        end else if (b == dfcf_pkg::CODE_END) begin
            if (open_fields > 0) begin
                if (instr_open[open_fields - 1] && hidden_fields > 0) hidden_fields--;
                instr_open[open_fields - 1] = 1'b0;
                open_fields--;
            end
        end else if (hidden_fields == 0) begin
            if (b == dfcf_pkg::CODE_TAB) begin
                r.kept     = 1'b1;
                r.out_byte = b;
            end else if (b == dfcf_pkg::CODE_NBHYPHEN) begin
                r.kept     = 1'b1;
                r.out_byte = dfcf_pkg::HYPHEN_CHAR;
            end else if (b >= dfcf_pkg::FIRST_PRINTABLE) begin
                r.kept     = 1'b1;
                r.out_byte = b;
            end
        end
        r.ovf = overflow_flag;
        return r;
    endfunction

    // Text content for random fields: half printable, with a good share of control
    // bytes and the bytes that get special treatment.
    function automatic logic [7:0] pick_text_byte();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50) begin
            return 8'($urandom_range(255, 32));
        end else if (roll < 75) begin
            return 8'($urandom_range(31, 0));
        end else if (roll < 83) begin
            return dfcf_pkg::CODE_TAB;
        end else if (roll < 91) begin
            return dfcf_pkg::CODE_NBHYPHEN;
        end
        return dfcf_pkg::CODE_OPTHYPHEN;
    endfunction

    // Random walk over field structure. Depth follows the predictor, so ends get more
    // likely as nesting grows and most sequences close properly; stray separators and
    // ends at the top level come out as noise.
    function automatic logic [7:0] pick_stream_byte();
        int unsigned roll;
        int unsigned end_weight;
        roll = $urandom_range(99);
        end_weight = (open_fields > 4) ? 20 : 10;
        if (roll < 14) begin
            return dfcf_pkg::CODE_BEGIN;
        end else if (roll < 24) begin
            return dfcf_pkg::CODE_SEP;
        end else if (roll < 24 + end_weight) begin
            return dfcf_pkg::CODE_END;
        end
        return pick_text_byte();
    endfunction

    function automatic logic calm_stretch();
        return bytes_sent >= CALM_FROM && bytes_sent < CALM_TO;
    endfunction

    // Offers one item, idling first at random, and returns at the edge that accepts it.
    // The expectation is queued at acceptance, ahead of the result the block makes.
    task automatic send_byte(input logic [7:0] b, input logic fixed, input filt_result_t want);
        filt_result_t predicted;
        while (!calm_stretch() && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = filter_byte(b);
        if (fixed) predicted = want;
        filtered_q = {filtered_q, predicted};
        bytes_sent++;
    endtask

    // Reset, then the directed table, then random field streams, then the drain.
    initial begin
        for (int i = 0; i < NEST_DEPTH; i++) instr_open[i] = 1'b0;
        open_fields   = 0;
        hidden_fields = 0;
        overflow_flag = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            for (int k = 0; k < DIRECTED[row].reps; k++) begin
                send_byte(DIRECTED[row].in_byte, DIRECTED[row].fixed,
                          '{DIRECTED[row].kept, DIRECTED[row].out_byte, DIRECTED[row].ovf});
            end
        end

        for (int n = 0; n < RANDOM_BYTES; n++) begin
            send_byte(pick_stream_byte(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        // The watchdog ends the run if the last results never come.
        while (filtered_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && filtered_q.size() == 0) begin
            $display("PASS doc_field_code_text_filter");
        end else begin
            $display("FAIL doc_field_code_text_filter");
        end
        $finish;
    end

    // Receiver side. It stalls at random, except during the no-idle stretch, and once
    // holds m_ready low long enough for the block to fill up and push back on s_ready.
    initial begin
        int hold_count;
        logic held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && bytes_sent >= HOLD_AT) begin
                held = 1'b1;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                    hold_count++;
                end
            end
            m_ready <= calm_stretch() || ($urandom_range(99) >= IDLE_PERCENT);
            @(posedge aclk);
        end
    end

    // Scoreboard: every accepted result item is matched against the oldest expectation.
    always @(posedge aclk) begin
        filt_result_t exp_item;
        if (aresetn && m_valid && m_ready) begin
            if (filtered_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 40) begin
                    $display("%0t: expected no item, actual %0b/%02h/%0b",
                             $time, m_kept, m_out_byte, m_nest_overflow);
                end
            end else begin
                exp_item = filtered_q.pop_front();
                if (m_kept !== exp_item.kept || m_out_byte !== exp_item.out_byte ||
                    m_nest_overflow !== exp_item.ovf) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 40) begin
                        $display("%0t: expected %0b/%02h/%0b, actual %0b/%02h/%0b",
                                 $time, exp_item.kept, exp_item.out_byte, exp_item.ovf,
                                 m_kept, m_out_byte, m_nest_overflow);
                    end
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no handshake on either channel means the
    // block has hung.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL doc_field_code_text_filter");
                $finish;
            end
        end
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/dfcf_pkg.sv
rtl/core/dfcf_stack.sv
rtl/core/dfcf_map.sv
rtl/core/doc_field_code_text_filter.sv
tb/tb_doc_field_code_text_filter.sv
